// File: src/bsc_pkg.sv
// shared types, constants and field helpers for the barometric compensation block
// used by every module under src
package bsc_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 48;
	localparam int QuoW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CAL_A = 3'd0,
		REG_CAL_B = 3'd1,
		REG_CAL_C = 3'd2,
		REG_CAL_D = 3'd3,
		REG_OSS = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [18:0] raw_pressure;
	} in_item_t;

	typedef struct packed {
		logic signed [27:0] temperature_tenths;
		logic signed [31:0] pressure_pa;
		logic divide_error;
	} out_item_t;

	typedef struct packed {
		logic [47:0] cal_a;
		logic [47:0] cal_b;
		logic [31:0] cal_c;
		logic [31:0] cal_d;
		logic [1:0] oversampling;
	} cal_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
		asr32 = 32'($signed(v) >>> s);
	endfunction

endpackage

// File: src/barometric_sensor_compensation.sv
// Barometric pressure and temperature compensation, fully pipelined.
// Items enter on start/busy; busy is always low so an item can enter every cycle.
// Configuration is written on cfg_valid/cfg_ready (cfg_ready always high);
// cfg_index selects cal_a, cal_b, cal_c, cal_d or oversampling, other indexes ignored.
// Each item gives one result on done for one cycle, in order, after it is
// accepted and passes two 32-stage divider pipelines plus nine other register stages.
// Throughput is one item per cycle; the dividers are the deepest parts.
// Reset clears calibration registers and all valid bits; no item is in flight after.
// The receiver cannot stall, so results are never held.
// A zero temperature divisor or zero pressure divisor sets divide_error and
// forces both results to zero.
// Configuration must only change while no item is in flight.
module barometric_sensor_compensation (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bsc_pkg::in_item_t in_item,
	output logic done,
	output bsc_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bsc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [bsc_pkg::CfgDataW-1:0] cfg_data
);
	import bsc_pkg::*;

	cal_t cal_q;
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [1:0] oss;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CAL_A: cal_q.cal_a <= cfg_data[47:0];
				REG_CAL_B: cal_q.cal_b <= cfg_data[47:0];
				REG_CAL_C: cal_q.cal_c <= cfg_data[31:0];
				REG_CAL_D: cal_q.cal_d <= cfg_data[31:0];
				REG_OSS: cal_q.oversampling <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ac1 = sx16(cal_q.cal_a[15:0]);
		ac2 = sx16(cal_q.cal_a[31:16]);
		ac3 = sx16(cal_q.cal_a[47:32]);
		ac4 = {16'd0, cal_q.cal_b[15:0]};
		ac5 = {16'd0, cal_q.cal_b[31:16]};
		ac6 = {16'd0, cal_q.cal_b[47:32]};
		b1 = sx16(cal_q.cal_c[15:0]);
		b2 = sx16(cal_q.cal_c[31:16]);
		mc = sx16(cal_q.cal_d[15:0]);
		md = sx16(cal_q.cal_d[31:16]);
		oss = cal_q.oversampling;
	end

	// s1: x1
	logic v_s1;
	logic [31:0] x1_s1;
	logic [18:0] up_s1;
	logic [31:0] ut_d;
	assign ut_d = {16'd0, in_item.raw_temperature} - ac6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		x1_s1 <= asr32(32'(ut_d * ac5), 15);
		up_s1 <= in_item.raw_pressure;
	end

	// s2: signed divide setup for x2 = (mc<<11)/den
	logic v_s2, tneg_s2, terr_s2;
	logic [31:0] x1_s2, tnum_s2, tden_s2;
	logic [18:0] up_s2;
	logic [31:0] den, mcs;
	assign den = x1_s1 + md;
	assign mcs = mc << 11;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		x1_s2 <= x1_s1;
		up_s2 <= up_s1;
		terr_s2 <= (den == 32'd0);
		tneg_s2 <= mcs[31] ^ den[31];
		tnum_s2 <= mcs[31] ? 32'(-mcs) : mcs;
		tden_s2 <= den[31] ? 32'(-den) : den;
	end

	localparam int TTagW = 32 + 19 + 2;
	logic v_d1;
	logic [31:0] q_d1;
	logic [TTagW-1:0] tag_d1;

	bsc_div #(.TagW(TTagW)) u_tdiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s2), .dividend(tnum_s2), .divisor(tden_s2 | {31'd0, terr_s2}),
		.in_tag({x1_s2, up_s2, tneg_s2, terr_s2}),
		.out_valid(v_d1), .quotient(q_d1), .out_tag(tag_d1)
	);

	// s3: b5, b6
	logic v_s3, err_s3;
	logic [31:0] b5_s3, b6_s3;
	logic [18:0] up_s3;
	logic [31:0] x2_t, b5_t;
	assign x2_t = tag_d1[1] ? 32'(-q_d1) : q_d1;
	assign b5_t = tag_d1[TTagW-1 -: 32] + x2_t;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_d1;
	end
	always_ff @(posedge clk) begin
		err_s3 <= tag_d1[0];
		b5_s3 <= b5_t;
		b6_s3 <= b5_t - 32'd4000;
		up_s3 <= tag_d1[20:2];
	end

	// s4: sq, ac2*b6, ac3*b6
	logic v_s4, err_s4;
	logic [31:0] b5_s4, sq_s4, p2_s4, p3_s4;
	logic [18:0] up_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		err_s4 <= err_s3;
		b5_s4 <= b5_s3;
		up_s4 <= up_s3;
		sq_s4 <= asr32(32'(b6_s3 * b6_s3), 12);
		p2_s4 <= asr32(32'(ac2 * b6_s3), 11);
		p3_s4 <= asr32(32'(ac3 * b6_s3), 13);
	end

	// s5: b2*sq, b1*sq, b3/x3 sums
	logic v_s5, err_s5;
	logic [31:0] b5_s5, b3_s5, x3_s5;
	logic [18:0] up_s5;
	logic [31:0] t1, t2, b3_t;
	assign t1 = asr32(32'(b2 * sq_s4), 11) + p2_s4;
	assign t2 = asr32(32'(b1 * sq_s4), 16);
	assign b3_t = asr32((((ac1 << 2) + t1) << oss) + 32'd2, 2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		err_s5 <= err_s4;
		b5_s5 <= b5_s4;
		up_s5 <= up_s4;
		b3_s5 <= b3_t;
		x3_s5 <= asr32(p3_s4 + t2 + 32'd2, 2);
	end

	// s6: b4, b7
	logic v_s6, err_s6;
	logic [31:0] b5_s6, b4_s6, b7_s6;
	logic [31:0] b4_t;
	logic [31:0] f50;
	assign f50 = 32'd50000 >> oss;
	assign b4_t = 32'(ac4 * (x3_s5 + 32'd32768)) >> 15;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		err_s6 <= err_s5 | (b4_t == 32'd0);
		b5_s6 <= b5_s5;
		b4_s6 <= b4_t;
		b7_s6 <= 32'(({13'd0, up_s5} - b3_s5) * f50);
	end

	localparam int PTagW = 32 + 2;
	logic v_d2;
	logic [31:0] q_d2, pnum;
	logic [PTagW-1:0] tag_d2;
	assign pnum = b7_s6[31] ? b7_s6 : (b7_s6 << 1);

	bsc_div #(.TagW(PTagW)) u_pdiv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s6), .dividend(pnum), .divisor(b4_s6 | {31'd0, err_s6}),
		.in_tag({b5_s6, b7_s6[31], err_s6}),
		.out_valid(v_d2), .quotient(q_d2), .out_tag(tag_d2)
	);

	// s7: p, (p>>8)^2, -7357*p
	logic v_s7, err_s7;
	logic [31:0] b5_s7, p_s7, sq8_s7, m2_s7;
	logic [31:0] p_t, ps;
	assign p_t = tag_d2[1] ? (q_d2 << 1) : q_d2;
	assign ps = asr32(p_t, 8);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_d2;
	end
	always_ff @(posedge clk) begin
		err_s7 <= tag_d2[0];
		b5_s7 <= tag_d2[PTagW-1 -: 32];
		p_s7 <= p_t;
		sq8_s7 <= 32'(ps * ps);
		m2_s7 <= asr32(32'(32'hFFFF_E343 * p_t), 16);
	end

	// s8: x1*3038
	logic v_s8, err_s8;
	logic [31:0] b5_s8, p_s8, m1_s8, m2_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		err_s8 <= err_s7;
		b5_s8 <= b5_s7;
		p_s8 <= p_s7;
		m2_s8 <= m2_s7;
		m1_s8 <= asr32(32'(sq8_s7 * 32'd3038), 16);
	end

	// s9: output
	logic v_s9;
	out_item_t res_s9;
	logic [31:0] pres_t, temp_t;
	assign pres_t = p_s8 + asr32(m1_s8 + m2_s8 + 32'd3791, 4);
	assign temp_t = asr32(b5_s8 + 32'd8, 4);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		res_s9.divide_error <= err_s8;
		res_s9.temperature_tenths <= err_s8 ? '0 : temp_t[27:0];
		res_s9.pressure_pa <= err_s8 ? '0 : pres_t;
	end

	assign done = v_s9;
	assign out_item = res_s9;
endmodule

// File: src/bsc_div.sv
// pipelined restoring divider, one quotient bit per stage, unsigned 32 by 32
// carries a tag alongside; depends on bsc_pkg
module bsc_div #(
	parameter int TagW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [bsc_pkg::QuoW-1:0] dividend,
	input logic [bsc_pkg::QuoW-1:0] divisor,
	input logic [TagW-1:0] in_tag,
	output logic out_valid,
	output logic [bsc_pkg::QuoW-1:0] quotient,
	output logic [TagW-1:0] out_tag
);
	import bsc_pkg::*;

	logic [QuoW-1:0] vld_s;
	logic [QuoW-1:0] rem_s [QuoW];
	logic [QuoW-1:0] num_s [QuoW];
	logic [QuoW-1:0] den_s [QuoW];
	logic [TagW-1:0] tag_s [QuoW];

	// one restoring step: shift in the next dividend bit, subtract when it fits
	function automatic logic [2*QuoW-1:0] div_step(input logic [QuoW-1:0] rem,
			input logic [QuoW-1:0] num, input logic [QuoW-1:0] den);
		logic [QuoW:0] trial;
		logic [QuoW:0] diff;
		trial = {rem, num[QuoW-1]};
		diff = trial - {1'b0, den};
		div_step = {diff[QuoW] ? trial[QuoW-1:0] : diff[QuoW-1:0],
			num[QuoW-2:0], ~diff[QuoW]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QuoW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		{rem_s[0], num_s[0]} <= div_step('0, dividend, divisor);
		den_s[0] <= divisor;
		tag_s[0] <= in_tag;
		for (int i = 1; i < QuoW; i++) begin
			{rem_s[i], num_s[i]} <= div_step(rem_s[i-1], num_s[i-1], den_s[i-1]);
			den_s[i] <= den_s[i-1];
			tag_s[i] <= tag_s[i-1];
		end
	end

	assign out_valid = vld_s[QuoW-1];
	assign quotient = num_s[QuoW-1];
	assign out_tag = tag_s[QuoW-1];
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for barometric_sensor_compensation: directed table plus random samples
// checked against an in-bench compensation predictor; depends on src/bsc_pkg.sv
module tb_top;
	import bsc_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t in_item;
	logic done;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	barometric_sensor_compensation u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int DrainCycles = 200;

	logic [47:0] m_cal_a, m_cal_b;
	logic [31:0] m_cal_c, m_cal_d;
	logic [1:0] m_oss;
	out_item_t comp_q[$];
	int errors;

	typedef struct {
		logic [15:0] ut;
		logic [18:0] up;
		bit fixed;
		out_item_t res;
	} stim_row_t;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] v, input int s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sdivw(input logic [31:0] n, input logic [31:0] d);
		longint q;
		q = longint'($signed(n)) / longint'($signed(d));
		return q[31:0];
	endfunction

	function automatic out_item_t compensate(input logic [15:0] ut, input logic [18:0] up);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b5, b6, b3, b4, b7, p, sq, tmp, prs;
		int md_s;
		out_item_t r;
		ac1 = sext(m_cal_a[15:0]); ac2 = sext(m_cal_a[31:16]); ac3 = sext(m_cal_a[47:32]);
		ac4 = {16'd0, m_cal_b[15:0]}; ac5 = {16'd0, m_cal_b[31:16]};
		ac6 = {16'd0, m_cal_b[47:32]};
		b1 = sext(m_cal_c[15:0]); b2 = sext(m_cal_c[31:16]);
		mc = sext(m_cal_d[15:0]); md = sext(m_cal_d[31:16]);
		md_s = m_oss;
		r = '0;
		r.divide_error = 1'b1;
		x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0) return r;
		x2 = sdivw(mc << 11, den);
		b5 = x1 + x2;
		tmp = sra(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = sra(b6 * b6, 12);
		x1 = sra(b2 * sq, 11);
		x2 = sra(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sra(((ac1 * 32'd4 + x3) << md_s) + 32'd2, 2);
		x1 = sra(ac3 * b6, 13);
		x2 = sra(b1 * sq, 16);
		x3 = sra(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) return r;
		b7 = ({13'd0, up} - b3) * (32'd50000 >> md_s);
		if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
		else p = (b7 / b4) << 1;
		x1 = sra(p, 8) * sra(p, 8);
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra((32'd0 - 32'd7357) * p, 16);
		prs = p + sra(x1 + x2 + 32'd3791, 4);
		r.temperature_tenths = tmp[27:0];
		r.pressure_pa = prs;
		r.divide_error = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && done) begin
			if (comp_q.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				e = comp_q.pop_front();
				if (out_item.temperature_tenths !== e.temperature_tenths)
					report_mismatch("temperature_tenths", out_item.temperature_tenths,
						e.temperature_tenths);
				if (out_item.pressure_pa !== e.pressure_pa)
					report_mismatch("pressure_pa", out_item.pressure_pa, e.pressure_pa);
				if (out_item.divide_error !== e.divide_error)
					report_mismatch("divide_error", out_item.divide_error, e.divide_error);
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CAL_A: m_cal_a = val;
			REG_CAL_B: m_cal_b = val;
			REG_CAL_C: m_cal_c = val[31:0];
			REG_CAL_D: m_cal_d = val[31:0];
			REG_OSS: m_oss = val[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_cal(input logic [47:0] a, input logic [47:0] b,
			input logic [31:0] c, input logic [31:0] d, input logic [1:0] oss);
		write_reg(REG_CAL_A, a);
		write_reg(REG_CAL_B, b);
		write_reg(REG_CAL_C, {16'd0, c});
		write_reg(REG_CAL_D, {16'd0, d});
		write_reg(REG_OSS, {46'd0, oss});
	endtask

	task automatic wait_idle();
		int n;
		start <= 1'b0;
		n = 0;
		while (comp_q.size() != 0 && n < 100000) begin
			@(negedge clk);
			n++;
		end
		repeat (DrainCycles) @(negedge clk);
	endtask

	// one sample; gap drawn per item, no gap in some stretches
	task automatic send_sample(input logic [15:0] ut, input logic [18:0] up,
			input bit fixed, input out_item_t res, input bit nogap);
		int gap;
		gap = nogap ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		in_item <= {ut, up};
		do @(posedge clk); while (busy);
		comp_q.push_back(fixed ? res : compensate(ut, up));
		@(negedge clk);
	endtask

	stim_row_t rows[$];

	function automatic stim_row_t mk(input logic [15:0] ut, input logic [18:0] up,
			input bit fixed, input logic signed [27:0] t, input logic signed [31:0] p,
			input logic de);
		stim_row_t s;
		s.ut = ut; s.up = up; s.fixed = fixed;
		s.res.temperature_tenths = t; s.res.pressure_pa = p; s.res.divide_error = de;
		return s;
	endfunction

	initial begin
		bit nogap;
		errors = 0;
		start = 0;
		in_item = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		m_cal_a = '0; m_cal_b = '0; m_cal_c = '0; m_cal_d = '0; m_oss = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// after reset all calibration is zero: temperature divisor is zero
		rows.push_back(mk(16'd0, 19'd0, 1, 0, 0, 1));
		rows.push_back(mk(16'hFFFF, 19'h7FFFF, 1, 0, 0, 1));
		rows.push_back(mk(16'd27898, 19'd23843, 1, 0, 0, 1));
		foreach (rows[i]) send_sample(rows[i].ut, rows[i].up, rows[i].fixed, rows[i].res, 0);
		wait_idle();

		// datasheet example calibration, then extremes
		write_cal({16'hC7D1 /* -14383 */, 16'hFFB8 /* -72 */, 16'd408},
			{16'd23153, 16'd32757, 16'd32741}, {16'd4, 16'd6190},
			{16'd2868, 16'hDDF9 /* -8711 */}, 2'd0);
		rows.delete();
		rows.push_back(mk(16'd27898, 19'd23843, 1, 150, 69964, 0));
		rows.push_back(mk(16'd0, 19'd0, 0, 0, 0, 0));
		rows.push_back(mk(16'hFFFF, 19'h7FFFF, 0, 0, 0, 0));
		rows.push_back(mk(16'h8000, 19'h40000, 0, 0, 0, 0));
		rows.push_back(mk(16'h5555, 19'h2AAAA, 0, 0, 0, 0));
		rows.push_back(mk(16'hAAAA, 19'h55555, 0, 0, 0, 0));
		foreach (rows[i]) send_sample(rows[i].ut, rows[i].up, rows[i].fixed, rows[i].res, 0);
		wait_idle();

		// zero pressure divisor: ac4 zero, temperature path live
		write_reg(REG_CAL_B, {16'd32741, 16'd32757, 16'd0});
		write_reg(REG_OSS, 48'd3);
		send_sample(16'd27898, 19'd23843, 1, '{28'sd0, 32'sd0, 1'b1}, 0);
		send_sample(16'hFFFF, 19'h7FFFF, 1, '{28'sd0, 32'sd0, 1'b1}, 0);
		wait_idle();

		// extreme calibration, wide writes with upper bits set
		write_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
		write_reg(REG_CAL_C, 48'hFFFF_FFFF_FFFF);
		send_sample(16'd0, 19'd0, 0, '0, 0);
		send_sample(16'hFFFF, 19'h7FFFF, 0, '0, 0);
		wait_idle();
		write_cal(48'h8000_8000_8000, 48'h0001_0001_0001, 32'h8000_8000, 32'h7FFF_8000, 2'd1);
		send_sample(16'd1, 19'd1, 0, '0, 0);
		send_sample(16'h7FFF, 19'h3FFFF, 0, '0, 0);
		wait_idle();

		// random phases: mostly near datasheet values, some fully random calibration
		for (int ph = 0; ph < 13; ph++) begin
			if (ph % 3 == 2)
				write_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
					$urandom, 2'($urandom));
			else
				write_cal({16'($urandom_range(0, 65535)), 16'(-($urandom_range(0, 200))),
					16'($urandom_range(0, 20000) - 10000)},
					{16'($urandom_range(20000, 40000)), 16'($urandom_range(20000, 32767)),
					16'($urandom_range(20000, 40000))},
					{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))},
					{16'(-$urandom_range(1, 12000)), 16'($urandom_range(0, 65535))},
					2'(ph % 4));
			for (int k = 0; k < 50; k++) begin
				nogap = (k % 20) < 6;
				if ($urandom_range(0, 3) == 0)
					send_sample(16'($urandom), 19'($urandom), 0, '0, nogap);
				else
					send_sample(16'($urandom_range(20000, 36000)),
						19'($urandom_range(20000, 90000)), 0, '0, nogap);
			end
			wait_idle();
		end

		wait_idle();
		if (comp_q.size() != 0)
			report_mismatch("items still expected", comp_q.size(), 0);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
